// ===== rtl/core/ppe_pkg.sv =====
package ppe_pkg;

  localparam int XW = 16;
  localparam int CW = 24;
  localparam int OW = 32;
  localparam int QW = 26;
  localparam int RW = 35;
  localparam int IDXW = 3;
  localparam int EXP_DEPTH = 10;
  localparam int PIPE_DEPTH = 12;

  localparam int EXP_ARG_CAP = 655;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [23:0] LN2_Q24 = 24'd11629080;
  localparam logic [25:0] ONE_Q24 = 26'd16777216;
  localparam logic [15:0] RECIP6 = 16'd43691;
  localparam logic [CW-1:0] POS_SLOPE_RST = 24'd65536;

  typedef enum logic [IDXW-1:0] {
    REG_EXP_SLOPE   = 3'd0,
    REG_CUBIC_COEF  = 3'd1,
    REG_SQUARE_COEF = 3'd2,
    REG_LINEAR_COEF = 3'd3,
    REG_CONST_COEF  = 3'd4,
    REG_POS_SLOPE   = 3'd5,
    REG_POS_OFFSET  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] exp_slope;
    logic signed [CW-1:0] cubic_coef;
    logic signed [CW-1:0] square_coef;
    logic signed [CW-1:0] linear_coef;
    logic signed [CW-1:0] const_coef;
    logic signed [CW-1:0] pos_slope;
    logic signed [CW-1:0] pos_offset;
  } coefs_t;

  // 2^(i/16) in q.24
  function automatic logic [24:0] pow2_frac(input logic [3:0] idx);
    logic [24:0] v;
    unique case (idx)
      4'd0:  v = 25'd16777216;
      4'd1:  v = 25'd17520007;
      4'd2:  v = 25'd18295684;
      4'd3:  v = 25'd19105703;
      4'd4:  v = 25'd19951585;
      4'd5:  v = 25'd20834917;
      4'd6:  v = 25'd21757357;
      4'd7:  v = 25'd22720638;
      4'd8:  v = 25'd23726566;
      4'd9:  v = 25'd24777031;
      4'd10: v = 25'd25874004;
      4'd11: v = 25'd27019544;
      4'd12: v = 25'd28215802;
      4'd13: v = 25'd29465022;
      4'd14: v = 25'd30769550;
      4'd15: v = 25'd32131834;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/ppe_cfg.sv =====
module ppe_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ppe_pkg::IDXW-1:0]      cfg_index,
  input  logic [ppe_pkg::CW-1:0]        cfg_data,
  output ppe_pkg::coefs_t               coefs
);
  import ppe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.exp_slope <= '0;
      coefs.cubic_coef <= '0;
      coefs.square_coef <= '0;
      coefs.linear_coef <= '0;
      coefs.const_coef <= '0;
      coefs.pos_slope <= POS_SLOPE_RST;
      coefs.pos_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_EXP_SLOPE:   coefs.exp_slope <= cfg_data;
        REG_CUBIC_COEF:  coefs.cubic_coef <= cfg_data;
        REG_SQUARE_COEF: coefs.square_coef <= cfg_data;
        REG_LINEAR_COEF: coefs.linear_coef <= cfg_data;
        REG_CONST_COEF:  coefs.const_coef <= cfg_data;
        REG_POS_SLOPE:   coefs.pos_slope <= cfg_data;
        REG_POS_OFFSET:  coefs.pos_offset <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/ppe_poly.sv =====
module ppe_poly (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ppe_pkg::XW-1:0]     x,
  input  ppe_pkg::coefs_t                   coefs,
  output logic signed [ppe_pkg::RW-1:0]     r16
);
  import ppe_pkg::*;

  logic signed [40:0] acc1;
  logic signed [44:0] acc2;
  logic signed [46:0] acc3;
  logic signed [XW-1:0] x1;
  logic signed [XW-1:0] x2;
  logic signed [56:0] prod2;
  logic signed [56:0] prod2_rnd;
  logic signed [60:0] prod3;
  logic signed [60:0] prod3_rnd;
  logic signed [46:0] acc3_rnd;
  logic signed [RW-1:0] rdly [4:EXP_DEPTH];

  assign prod2 = 57'(acc1) * 57'(x1);
  assign prod2_rnd = prod2 + 57'sd2048;
  assign prod3 = 61'(acc2) * 61'(x2);
  assign prod3_rnd = prod3 + 61'sd2048;
  assign acc3_rnd = acc3 + 47'sd2048;

  always_ff @(posedge clk) begin
    if (en) begin
      // horner, q.28
      acc1 <= 41'(coefs.cubic_coef) * 41'(x) + (41'(coefs.square_coef) <<< 12);
      x1 <= x;
      acc2 <= prod2_rnd[56:12] + (45'(coefs.linear_coef) <<< 12);
      x2 <= x1;
      acc3 <= prod3_rnd[58:12] + (47'(coefs.const_coef) <<< 12);
      rdly[4] <= acc3_rnd[46:12];
      for (int i = 5; i <= EXP_DEPTH; i++) begin
        rdly[i] <= rdly[i-1];
      end
    end
  end

  assign r16 = rdly[EXP_DEPTH];

endmodule

// ===== rtl/core/ppe_exp.sv =====
module ppe_exp (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ppe_pkg::XW-1:0]     x,
  input  logic signed [ppe_pkg::CW-1:0]     k,
  output logic [ppe_pkg::QW-1:0]            q
);
  import ppe_pkg::*;

  typedef struct packed {
    logic [3:0] idx;
    logic       zero;
    logic       under;
    logic [5:0] sh_m1;
  } exp_ctl_t;

  localparam logic signed [27:0] P_CAP = 28'(EXP_ARG_CAP);

  logic signed [39:0] kx;
  logic signed [39:0] kx_rnd;
  logic signed [27:0] p_full;
  logic signed [27:0] p;
  logic signed [59:0] yprod;
  logic signed [59:0] y_rnd;
  logic signed [37:0] y;
  logic signed [13:0] e;
  exp_ctl_t ctl_next;
  exp_ctl_t ctl [4:9];
  logic [43:0] uprod;
  logic [44:0] u_sum;
  logic [19:0] u;
  logic [39:0] u2prod;
  logic [19:0] u_s5;
  logic [40:0] u2_sum;
  logic [16:0] u2;
  logic [36:0] u3prod;
  logic [19:0] u_s6;
  logic [16:0] u2_s6;
  logic [37:0] u3_sum;
  logic [13:0] u3;
  logic [30:0] d6prod;
  logic [19:0] u_s7;
  logic [16:0] u2_s7;
  logic [17:0] u2_half;
  logic [25:0] poly;
  logic [50:0] mprod;
  logic [51:0] m_sum;
  logic [25:0] mant;
  logic [25:0] mant_sh;
  logic [26:0] q_sum;

  assign kx_rnd = kx + 40'sd2048;
  assign p_full = kx_rnd[39:12];
  assign y_rnd = yprod + 60'sd2097152;
  assign y = y_rnd[59:22];
  assign e = y[37:24];

  always_comb begin
    ctl_next.idx = y[23:20];
    ctl_next.zero = (e == 14'sd0);
    ctl_next.under = (e < -14'sd40);
    ctl_next.sh_m1 = ~e[5:0];
  end

  assign u_sum = {1'b0, uprod} + 45'd8388608;
  assign u = u_sum[43:24];
  assign u2_sum = {1'b0, u2prod} + 41'd8388608;
  assign u2 = u2_sum[40:24];
  assign u3_sum = {1'b0, u3prod} + 38'd8388608;
  assign u3 = u3_sum[37:24];
  assign u2_half = {1'b0, u2_s7} + 18'd1;
  assign m_sum = {1'b0, mprod} + 52'd8388608;
  assign mant = m_sum[49:24];
  assign mant_sh = mant >> ctl[9].sh_m1;
  assign q_sum = {1'b0, mant_sh} + 27'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      kx <= 40'(k) * 40'(x);
      p <= (p_full > P_CAP) ? P_CAP : p_full;
      yprod <= 60'(p) * 60'($signed({1'b0, LOG2E_Q30}));
      // split y into integer shift, table index and remainder
      uprod <= 44'(y[19:0]) * 44'(LN2_Q24);
      ctl[4] <= ctl_next;
      for (int i = 5; i <= 9; i++) begin
        ctl[i] <= ctl[i-1];
      end
      u2prod <= 40'(u) * 40'(u);
      u_s5 <= u;
      u3prod <= 37'(u2) * 37'(u_s5);
      u_s6 <= u_s5;
      u2_s6 <= u2;
      d6prod <= 31'({1'b0, u3} + 15'd3) * 31'(RECIP6);
      u_s7 <= u_s6;
      u2_s7 <= u2_s6;
      poly <= ONE_Q24 + 26'(u_s7) + 26'(u2_half[17:1]) + 26'(d6prod[30:18]);
      mprod <= 51'(pow2_frac(ctl[8].idx)) * 51'(poly);
      if (ctl[9].zero) begin
        q <= mant;
      end else if (ctl[9].under) begin
        q <= '0;
      end else begin
        q <= q_sum[26:1];
      end
    end
  end

endmodule

// ===== rtl/core/piecewise_poly_exp_activation.sv =====
// piecewise polynomial-times-exponential activation
//
// s_axis carries one q4.12 sample per transaction; m_axis returns one
// q16.16 result per sample, in order, with tuser set when it was clipped.
// for x > 0 the result is m*x+n, otherwise (a*x^3+b*x^2+c*x+d)*exp(min(k*x,0.01)).
// coefficients are written over the cfg channel (index 0..6, q8.16); cfg_ready is
// always high. writes must go in while the pipeline is empty, unchecked by the block.
//
// one sample is taken every cycle unless m_axis stalls. the pipeline depth
// is set by the exponential path, which runs a chain of registered
// multipliers (k*x, log2 e, remainder cubic, table product) ahead of the
// final polynomial-times-exponential product.
//
// reset empties the pipeline and loads the default coefficients
// (pos_slope = 1.0, all others 0). when the receiver holds m_axis_tready
// low with a result waiting, the whole pipeline freezes and s_axis_tready
// drops in the same cycle; nothing is dropped or repeated.
module piecewise_poly_exp_activation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ppe_pkg::XW-1:0]        s_axis_tdata,   // [15:0] sample_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ppe_pkg::OW-1:0]        m_axis_tdata,   // [31:0] sample_out
  output logic [0:0]                    m_axis_tuser,   // [0] saturated
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppe_pkg::IDXW-1:0]      cfg_index,
  input  logic [ppe_pkg::CW-1:0]        cfg_data
);
  import ppe_pkg::*;

  coefs_t coefs;
  logic adv;
  logic [PIPE_DEPTH-1:0] vld;
  logic signed [XW-1:0] xd [1:EXP_DEPTH];
  logic signed [RW-1:0] r16;
  logic [QW-1:0] q;
  logic signed [39:0] mx;
  logic pos_sel;
  logic signed [61:0] prod;
  logic signed [39:0] mx_rnd;
  logic signed [37:0] pos_res;
  logic signed [61:0] prod_rnd;
  logic signed [37:0] res;
  logic sat_hi;
  logic sat_lo;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = vld[PIPE_DEPTH-1];

  ppe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  ppe_poly u_poly (
    .clk   (clk),
    .en    (adv),
    .x     ($signed(s_axis_tdata)),
    .coefs (coefs),
    .r16   (r16)
  );

  ppe_exp u_exp (
    .clk (clk),
    .en  (adv),
    .x   ($signed(s_axis_tdata)),
    .k   (coefs.exp_slope),
    .q   (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  assign mx_rnd = mx + 40'sd2048;
  assign pos_res = 38'($signed(mx_rnd[39:12])) + 38'(coefs.pos_offset);
  assign prod_rnd = prod + 62'sd8388608;
  assign res = pos_sel ? pos_res : prod_rnd[61:24];
  assign sat_hi = res > 38'sd2147483647;
  assign sat_lo = res < -38'sd2147483648;

  always_ff @(posedge clk) begin
    if (adv) begin
      xd[1] <= $signed(s_axis_tdata);
      for (int i = 2; i <= EXP_DEPTH; i++) begin
        xd[i] <= xd[i-1];
      end
      mx <= 40'(coefs.pos_slope) * 40'(xd[EXP_DEPTH]);
      pos_sel <= xd[EXP_DEPTH] > 16'sd0;
      prod <= 62'(r16) * 62'($signed({1'b0, q}));
      // clip to q16.16
      if (sat_hi) begin
        m_axis_tdata <= 32'h7fff_ffff;
      end else if (sat_lo) begin
        m_axis_tdata <= 32'h8000_0000;
      end else begin
        m_axis_tdata <= res[OW-1:0];
      end
      m_axis_tuser <= sat_hi || sat_lo;
    end
  end

endmodule

// ===== rtl/core/ppe_chk.sv =====
module ppe_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // empty output stage never blocks the input
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output stage");

  // clip flag only with a rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata == 32'h7fff_ffff) || (m_axis_tdata == 32'h8000_0000))
    else $error("saturation flag without rail value");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind piecewise_poly_exp_activation ppe_chk u_chk (.*);
